### src/fkvp_pkg.sv
// fkvp_pkg: shared types and constants for the framed key/value message parser
// result beat layout, kind codes and framing characters
// no dependencies
`default_nettype none

package fkvp_pkg;

  typedef enum logic [2:0] {
    KIND_METHOD   = 3'd0,
    KIND_KEY      = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_OK       = 3'd3,
    KIND_FORMAT   = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  localparam int unsigned LEN_W = 7;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] msg_len;
  } result_t;

  localparam logic [7:0] START_CH = 8'h23;  // '#'
  localparam logic [7:0] END_CH   = 8'h5E;  // '^'
  localparam logic [7:0] SEP_CH   = 8'h3F;  // '?'
  localparam logic [7:0] DIV_CH   = 8'h3D;  // '='
  localparam int unsigned MIN_MSG = 4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

### src/fkvp_front.sv
// fkvp_front: accepts received bytes, tracks framing and classifies each byte
// depends on fkvp_pkg
`default_nettype none

module fkvp_front #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        rx_byte,
  output fkvp_pkg::result_t      res,
  output logic                   res_valid
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned LW = fkvp_pkg::LEN_W;

  typedef enum logic [1:0] {
    PH_METHOD = 2'd0,
    PH_SEP    = 2'd1,
    PH_KEY    = 2'd2,
    PH_VALUE  = 2'd3
  } phase_t;

  logic          in_message, in_message_next;
  logic [7:0]    previous_byte;
  logic [CW-1:0] byte_count, byte_count_next;
  phase_t        field_phase, field_phase_next;
  logic          format_bad, format_bad_next;

  logic [CW-1:0]   count_inc;
  logic [LW-1:0]   count_len;
  logic            short_msg;

  assign count_inc = byte_count + CW'(1);
  assign count_len = LW'(count_inc);
  assign short_msg = (count_inc < CW'(fkvp_pkg::MIN_MSG));

  always_comb begin
    in_message_next  = in_message;
    byte_count_next  = byte_count;
    field_phase_next = field_phase;
    format_bad_next  = format_bad;
    res_valid        = 1'b0;
    res.kind         = fkvp_pkg::KIND_METHOD;
    res.data         = 8'd0;
    res.msg_len      = '0;

    if (!in_message) begin
      if (rx_byte == fkvp_pkg::START_CH && previous_byte == fkvp_pkg::START_CH) begin
        in_message_next  = 1'b1;
        byte_count_next  = '0;
        field_phase_next = PH_METHOD;
        format_bad_next  = 1'b0;
      end
    end else begin
      byte_count_next = count_inc;
      if (rx_byte == fkvp_pkg::END_CH) begin
        res_valid       = 1'b1;
        res.kind        = (format_bad || short_msg) ? fkvp_pkg::KIND_FORMAT
                                                    : fkvp_pkg::KIND_OK;
        res.msg_len     = count_len;
        in_message_next = 1'b0;
      end else if (count_inc >= CW'(MAX_LEN)) begin
        res_valid       = 1'b1;
        res.kind        = fkvp_pkg::KIND_OVERFLOW;
        res.msg_len     = count_len;
        in_message_next = 1'b0;
      end else begin
        if (rx_byte == 8'd0) begin
          format_bad_next = 1'b1;
        end
        case (field_phase)
          PH_METHOD: begin
            res_valid        = 1'b1;
            res.kind         = fkvp_pkg::KIND_METHOD;
            res.data         = rx_byte;
            field_phase_next = PH_SEP;
          end
          PH_SEP: begin
            if (rx_byte != fkvp_pkg::SEP_CH) begin
              format_bad_next = 1'b1;
            end
            field_phase_next = PH_KEY;
          end
          PH_KEY: begin
            if (rx_byte == fkvp_pkg::DIV_CH) begin
              field_phase_next = PH_VALUE;
            end else begin
              res_valid = 1'b1;
              res.kind  = fkvp_pkg::KIND_KEY;
              res.data  = rx_byte;
            end
          end
          default: begin
            res_valid = 1'b1;
            res.kind  = fkvp_pkg::KIND_VALUE;
            res.data  = rx_byte;
          end
        endcase
      end
    end
    res_valid = res_valid && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message    <= 1'b0;
      previous_byte <= 8'd0;
      byte_count    <= '0;
      field_phase   <= PH_METHOD;
      format_bad    <= 1'b0;
    end else if (take) begin
      in_message    <= in_message_next;
      previous_byte <= rx_byte;
      byte_count    <= byte_count_next;
      field_phase   <= field_phase_next;
      format_bad    <= format_bad_next;
    end
  end

endmodule

`default_nettype wire

### src/fkvp_queue.sv
// fkvp_queue: short result queue between the classifier and the output channel
// depends on fkvp_pkg
`default_nettype none

module fkvp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fkvp_pkg::result_t push_data,
  output logic                   has_room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fkvp_pkg::result_t      out_data
);

  localparam int unsigned CNT_W = fkvp_pkg::QPTR_W + 1;

  fkvp_pkg::result_t                slots [fkvp_pkg::QUEUE_DEPTH];
  logic [fkvp_pkg::QPTR_W-1:0]      wr_ptr;
  logic [fkvp_pkg::QPTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]                 fill;
  logic                             pop;
  logic                             do_push;

  assign has_room  = (fill != CNT_W'(fkvp_pkg::QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign do_push   = push && has_room;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + fkvp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + fkvp_pkg::QPTR_W'(1);
      end
      if (do_push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/framed_key_value_message_parser_top.sv
// framed_key_value_message_parser_top: byte-stream parser for framed key/value messages
// instantiates fkvp_front and fkvp_queue, uses fkvp_pkg
//
// usage
//   input channel: one received byte per beat on rx_byte, in_valid / in_ready
//   output channel: kind, data, msg_len per beat, out_valid / out_ready
//   "##" opens a message; the method byte, key bytes and value bytes come out
//   tagged, the '?' and the dividing '=' are dropped, '^' closes the message
//   with an ok or format-error beat, and an over-long message closes with an
//   overflow beat carrying MAX_LEN as its length
// timing
//   a result is written to the queue when its byte is taken and is shown from there;
//   throughput: one byte per cycle while the queue has room, set by the combinational
//   classifier and a four-entry result queue that can push and pop in the same cycle
// stalls and reset
//   while the receiver holds out_ready low the queue fills; in_ready drops
//   only once all four entries are taken, and nothing is lost or repeated
//   rst (synchronous, active high) empties the queue and returns the parser
//   to waiting for a start
`default_nettype none

module framed_key_value_message_parser_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      kind,
  output logic [7:0]      data,
  output logic [6:0]      msg_len
);

  fkvp_pkg::result_t res;
  fkvp_pkg::result_t out_res;
  logic              res_valid;
  logic              has_room;
  logic              take;

  // a byte is taken only when the queue can hold whatever it produces
  assign in_ready = has_room;
  assign take     = in_valid && has_room;

  fkvp_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .res       (res),
    .res_valid (res_valid)
  );

  fkvp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign kind    = out_res.kind;
  assign data    = out_res.data;
  assign msg_len = out_res.msg_len;

endmodule

`default_nettype wire
